// ===== rtl/cnlc_pkg.sv =====
package cnlc_pkg;

	localparam int CARD_W     = 54;
	localparam int BCD_DIGITS = 17;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int DD_STEP    = 6;
	localparam int DD_STAGES  = CARD_W / DD_STEP;
	localparam int SUM_W      = 8;
	localparam int COUNT_W    = 5;

	typedef enum logic [1:0] {
		BRAND_UNKNOWN = 2'd0,
		BRAND_PFX3    = 2'd1,
		BRAND_PFX4    = 2'd2,
		BRAND_PFX5    = 2'd3
	} brand_t;

	localparam logic [COUNT_W-1:0] LEN_PFX3   = 5'd15;
	localparam logic [COUNT_W-1:0] LEN_SHORT  = 5'd13;
	localparam logic [COUNT_W-1:0] LEN_LONG   = 5'd16;

endpackage

// ===== rtl/card_number_luhn_check_unit.sv =====
// Luhn check of a card number with brand class from length and prefix.
//
// Input: drive card_number and raise start; the number is transferred at a
// rising edge where start is high and busy is low. busy is high only while
// reset is applied and for the first cycle after it; after that a number can
// be transferred at every edge.
//
// Output: luhn_sum, luhn_valid, digit_count and brand are shown for exactly
// one cycle with done high, and the transfer completes at the edge that ends
// that cycle. One result leaves per cycle, in input order.
//
// The pipeline starts with the binary to decimal converter: nine stages of six
// shift-and-correct steps each, followed by a digit weighting stage, a sum
// and brand stage, and a modulo-ten output stage.
//
// The receiver cannot hold results off; results are dropped if not taken.
// Reset clears every valid bit, so no result appears from a partly filled
// pipeline.
module card_number_luhn_check_unit #(
	parameter int MAX_DIGITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [cnlc_pkg::CARD_W-1:0]    card_number,
	output logic                           done,
	output logic [cnlc_pkg::SUM_W-1:0]     luhn_sum,
	output logic                           luhn_valid,
	output logic [cnlc_pkg::COUNT_W-1:0]   digit_count,
	output logic [1:0]                     brand
);
	import cnlc_pkg::*;

	localparam int KD    = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
	localparam int NPAIR = (KD + 1) / 2;
	localparam int LAT   = DD_STAGES + 3;

	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
			input logic [DD_STEP-1:0] bits);
		logic [BCD_W-1:0] b;
		b = bcd;
		for (int s = DD_STEP - 1; s >= 0; s--) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (b[4*d +: 4] >= 4'd5)
					b[4*d +: 4] = b[4*d +: 4] + 4'd3;
			end
			b = {b[BCD_W-2:0], bits[s]};
		end
		return b;
	endfunction

	function automatic logic mod10_zero(input logic [SUM_W-1:0] s);
		logic r;
		r = 1'b0;
		for (int m = 0; m * 10 < (1 << SUM_W); m++) begin
			if (s == SUM_W'(m * 10))
				r = 1'b1;
		end
		return r;
	endfunction

	logic busy_q;
	logic accept;
	logic [LAT:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b1;
		else
			busy_q <= 1'b0;
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[LAT-1:1], accept};
	end

	// binary to decimal conversion, six bits per stage
	logic [BCD_W-1:0]  conv_bcd_s [1:DD_STAGES];
	logic [CARD_W-1:0] conv_rem_s [1:DD_STAGES-1];

	always_ff @(posedge clk) begin
		conv_bcd_s[1] <= dd_step('0, card_number[CARD_W-1 -: DD_STEP]);
		conv_rem_s[1] <= card_number << DD_STEP;
	end

	for (genvar k = 2; k <= DD_STAGES; k++) begin : g_conv
		always_ff @(posedge clk) begin
			conv_bcd_s[k] <= dd_step(conv_bcd_s[k-1],
				conv_rem_s[k-1][CARD_W-1 -: DD_STEP]);
		end
		if (k < DD_STAGES) begin : g_rem
			always_ff @(posedge clk) begin
				conv_rem_s[k] <= conv_rem_s[k-1] << DD_STEP;
			end
		end
	end

	// digit weighting, pair sums, length and leading digits
	logic [3:0]         dg [KD];
	logic [3:0]         wt [KD];
	logic [4:0]         psum [NPAIR];
	logic [COUNT_W-1:0] cnt_c;
	logic [3:0]         top_c;
	logic [3:0]         nxt_c;

	always_comb begin
		logic [4:0] d2;
		d2 = '0;
		for (int i = 0; i < KD; i++) begin
			dg[i] = conv_bcd_s[DD_STAGES][4*i +: 4];
			if (i % 2 == 1) begin
				d2 = {dg[i], 1'b0};
				if (d2 > 5'd9)
					d2 = d2 - 5'd9;
				wt[i] = d2[3:0];
			end else begin
				wt[i] = dg[i];
			end
		end
		for (int j = 0; j < NPAIR; j++) begin
			if (2 * j + 1 < KD)
				psum[j] = {1'b0, wt[2*j]} + {1'b0, wt[2*j+1]};
			else
				psum[j] = {1'b0, wt[2*j]};
		end
		cnt_c = '0;
		top_c = '0;
		nxt_c = '0;
		for (int i = 0; i < KD; i++) begin
			if (dg[i] != 4'd0) begin
				cnt_c = COUNT_W'(i + 1);
				top_c = dg[i];
				nxt_c = (i >= 1) ? dg[(i >= 1) ? i - 1 : 0] : 4'd0;
			end
		end
	end

	logic [4:0]         psum_s10 [NPAIR];
	logic [COUNT_W-1:0] cnt_s10;
	logic [3:0]         top_s10;
	logic [3:0]         nxt_s10;

	always_ff @(posedge clk) begin
		psum_s10 <= psum;
		cnt_s10  <= cnt_c;
		top_s10  <= top_c;
		nxt_s10  <= nxt_c;
	end

	// total and brand class
	logic [SUM_W-1:0] sum_c;
	brand_t           brand_c;

	always_comb begin
		sum_c = '0;
		for (int j = 0; j < NPAIR; j++)
			sum_c = sum_c + SUM_W'(psum_s10[j]);
		brand_c = BRAND_UNKNOWN;
		if (cnt_s10 >= 5'd2) begin
			if (cnt_s10 == LEN_PFX3 && top_s10 == 4'd3 &&
					(nxt_s10 == 4'd4 || nxt_s10 == 4'd7))
				brand_c = BRAND_PFX3;
			else if ((cnt_s10 == LEN_SHORT || cnt_s10 == LEN_LONG) && top_s10 == 4'd4)
				brand_c = BRAND_PFX4;
			else if (cnt_s10 == LEN_LONG && top_s10 == 4'd5 &&
					nxt_s10 >= 4'd1 && nxt_s10 <= 4'd5)
				brand_c = BRAND_PFX5;
		end
	end

	logic [SUM_W-1:0]   sum_s11;
	logic [COUNT_W-1:0] cnt_s11;
	brand_t             brand_s11;

	always_ff @(posedge clk) begin
		sum_s11   <= sum_c;
		cnt_s11   <= cnt_s10;
		brand_s11 <= brand_c;
	end

	// output register
	logic [SUM_W-1:0]   sum_s12;
	logic               valid_s12;
	logic [COUNT_W-1:0] cnt_s12;
	brand_t             brand_s12;

	always_ff @(posedge clk) begin
		sum_s12   <= sum_s11;
		valid_s12 <= mod10_zero(sum_s11);
		cnt_s12   <= cnt_s11;
		brand_s12 <= brand_s11;
	end

	assign done        = vld_s[LAT];
	assign luhn_sum    = sum_s12;
	assign luhn_valid  = valid_s12;
	assign digit_count = cnt_s12;
	assign brand       = brand_s12;

	ast_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##12 done)
		else $error("transfer did not produce a result after the pipeline latency");

	ast_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> digit_count <= COUNT_W'(KD))
		else $error("digit count above the kept digit slots");

	ast_brand_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && brand != BRAND_UNKNOWN |->
			digit_count == LEN_PFX3 || digit_count == LEN_SHORT || digit_count == LEN_LONG)
		else $error("brand class with an impossible length");

	ast_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && digit_count == '0 |-> luhn_sum == '0 && brand == BRAND_UNKNOWN)
		else $error("zero number gave a nonzero sum or a brand");

	ast_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> luhn_sum <= SUM_W'(9 * KD))
		else $error("sum above the largest weighted digit total");

endmodule
